// ===== rtl/tls_pkg.sv =====
// Shared types, constants and character classification for the token lexer.
`default_nettype none

package tls_pkg;

    localparam int POSITION_BITS      = 24;
    localparam int SPAN_BITS          = 24;
    localparam int KIND_BITS          = 5;
    localparam int KEYWORD_MAX_LENGTH = 6;
    localparam int KEYWORD_COUNT      = 7;
    localparam int WLEN_BITS          = $clog2(KEYWORD_MAX_LENGTH + 2);
    localparam int QUEUE_DEPTH        = 4;
    localparam int QPTR_BITS          = $clog2(QUEUE_DEPTH);
    localparam int IN_DATA_BITS       = 8;
    localparam int OUT_FIELD_BITS     = KIND_BITS + 2 * SPAN_BITS;
    localparam int OUT_DATA_BITS      = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef logic [POSITION_BITS-1:0]           pos_t;
    typedef logic [SPAN_BITS-1:0]               span_t;
    typedef logic [KIND_BITS-1:0]               kind_t;
    typedef logic [7:0]                         char_t;
    typedef logic [WLEN_BITS-1:0]               wlen_t;
    typedef logic [KEYWORD_MAX_LENGTH-1:0][7:0] word_t;

    localparam pos_t POS_MAX = '1;

    // token kinds
    localparam kind_t KIND_END       = 5'd0;
    localparam kind_t KIND_ERROR     = 5'd1;
    localparam kind_t KIND_NUMBER    = 5'd2;
    localparam kind_t KIND_IDENT     = 5'd3;
    localparam kind_t KIND_KW_BASE   = 5'd4;
    localparam kind_t KIND_ASSIGN    = 5'd11;
    localparam kind_t KIND_EQ        = 5'd12;
    localparam kind_t KIND_NE        = 5'd13;
    localparam kind_t KIND_PLUS      = 5'd14;
    localparam kind_t KIND_MINUS     = 5'd15;
    localparam kind_t KIND_STAR      = 5'd16;
    localparam kind_t KIND_SLASH     = 5'd17;
    localparam kind_t KIND_LBRACE    = 5'd18;
    localparam kind_t KIND_RBRACE    = 5'd19;
    localparam kind_t KIND_LPAREN    = 5'd20;
    localparam kind_t KIND_RPAREN    = 5'd21;
    localparam kind_t KIND_LBRACKET  = 5'd22;
    localparam kind_t KIND_RBRACKET  = 5'd23;
    localparam kind_t KIND_LT        = 5'd24;
    localparam kind_t KIND_LE        = 5'd25;
    localparam kind_t KIND_GT        = 5'd26;
    localparam kind_t KIND_GE        = 5'd27;
    localparam kind_t KIND_COLON     = 5'd28;
    localparam kind_t KIND_DEFINE    = 5'd29;
    localparam kind_t KIND_SEMI      = 5'd30;
    localparam kind_t KIND_AMP       = 5'd31;

    // keyword spellings, right-justified, and their lengths
    localparam logic [63:0] KW_TEXT [KEYWORD_COUNT] =
        '{"func", "return", "var", "set", "if", "else", "while"};
    localparam int KW_LEN [KEYWORD_COUNT] = '{4, 6, 3, 3, 2, 4, 5};

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_NUMBER,
        PEND_IDENT,
        PEND_OPFIRST
    } pend_t;

    typedef struct packed {
        kind_t kind;
        span_t start;
        span_t stop;
        logic  last;
    } token_t;

    // what one byte produced: one or two tokens
    typedef struct packed {
        token_t tok0;
        token_t tok1;
        logic   two;
    } record_t;

    function automatic logic is_digit(char_t c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_word_first(char_t c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_space(char_t c);
        return (c == " ") || (c == 8'h09) || (c == 8'h0A);
    endfunction

    function automatic logic is_op_first(char_t c);
        return (c == "=") || (c == "!") || (c == "<") || (c == ">") || (c == ":");
    endfunction

    function automatic pos_t pos_next(pos_t p);
        return (p == POS_MAX) ? POS_MAX : p + 1'b1;
    endfunction

    function automatic span_t to_span(pos_t p);
        return SPAN_BITS'(p);
    endfunction

    // lone character kind; anything unknown (a bare '!' too) is an error
    function automatic kind_t single_kind(char_t c);
        kind_t k;
        case (c)
            "=":     k = KIND_ASSIGN;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "[":     k = KIND_LBRACKET;
            "]":     k = KIND_RBRACKET;
            "<":     k = KIND_LT;
            ">":     k = KIND_GT;
            ":":     k = KIND_COLON;
            ";":     k = KIND_SEMI;
            "&":     k = KIND_AMP;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

    function automatic kind_t pair_kind(char_t c);
        kind_t k;
        case (c)
            "=":     k = KIND_EQ;
            "!":     k = KIND_NE;
            "<":     k = KIND_LE;
            ">":     k = KIND_GE;
            default: k = KIND_DEFINE;
        endcase
        return k;
    endfunction

    function automatic kind_t word_kind(word_t w, wlen_t len);
        kind_t k;
        logic  same;
        k = KIND_IDENT;
        for (int kw = KEYWORD_COUNT - 1; kw >= 0; kw--) begin
            same = (len == WLEN_BITS'(KW_LEN[kw]));
            for (int i = 0; i < KEYWORD_MAX_LENGTH; i++) begin
                if (i < KW_LEN[kw]) begin
                    if (w[i] != KW_TEXT[kw][8*(KW_LEN[kw]-1-i) +: 8]) begin
                        same = 1'b0;
                    end
                end
            end
            if (same) begin
                k = KIND_KW_BASE + KIND_BITS'(kw);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/token_lexer_stream_core.sv =====
// Top level of the streaming tokenizer: front end, record queue and token output stage.
`default_nettype none

// Takes one source byte per cycle and emits tokens (kind plus byte span) by longest match;
// an item with tlast set ends the text, giving any pending token and then an end record
// with tlast set, after which offsets restart at zero. A token leaves once its last byte
// or the byte after it (or the end of text) is taken, via the record queue and output
// register. Input runs at one byte per cycle; the output moves one token per cycle while
// m_tready is high, so a byte that closes one token and yields another needs two output
// transfers. A four-entry record queue absorbs these; s_tready drops only while it is full.
module token_lexer_stream_core
    import tls_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [IN_DATA_BITS-1:0]   s_tdata,   // [7:0] text_byte
    input  wire logic                      s_tlast,   // end_of_text
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [OUT_DATA_BITS-1:0]       m_tdata,   // [4:0] kind, [28:5] start, [52:29] end
    output logic                           m_tlast    // last_result
);

    logic    push, full, pop, empty;
    record_t push_rec, head;
    token_t  out_tok;

    assign s_tready = !full;

    tls_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_eot   (s_tlast),
        .push     (push),
        .push_rec (push_rec)
    );

    tls_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    tls_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    assign m_tdata = OUT_DATA_BITS'({out_tok.stop, out_tok.start, out_tok.kind});
    assign m_tlast = out_tok.last;

endmodule

`default_nettype wire

// ===== rtl/tls_front.sv =====
// Lexer front end: takes one byte per cycle while in_ready is high, tracks the token in progress, emits records.
`default_nettype none

module tls_front
    import tls_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    input  wire logic    in_ready,
    input  wire char_t   in_byte,
    input  wire logic    in_eot,
    output logic         push,
    output record_t      push_rec
);

    pos_t  pos_reg,   pos_next_v;
    pos_t  start_reg, start_next;
    pend_t pend_reg,  pend_next;
    word_t chars_reg, chars_next;
    wlen_t len_reg,   len_next;

    logic   accept;
    logic   close_v, new_v, fresh;
    token_t close_tok, new_tok;
    kind_t  close_kind;

    assign accept = in_valid && in_ready;

    always_comb begin
        case (pend_reg)
            PEND_NUMBER:  close_kind = KIND_NUMBER;
            PEND_IDENT:   close_kind = word_kind(chars_reg, len_reg);
            PEND_OPFIRST: close_kind = single_kind(chars_reg[0]);
            default:      close_kind = KIND_ERROR;
        endcase
        close_tok = '{kind: close_kind, start: to_span(start_reg),
                      stop: to_span(pos_reg), last: 1'b0};
    end

    always_comb begin
        pos_next_v = pos_reg;
        start_next = start_reg;
        pend_next  = pend_reg;
        chars_next = chars_reg;
        len_next   = len_reg;
        close_v    = 1'b0;
        new_v      = 1'b0;
        fresh      = 1'b0;
        new_tok    = '{kind: KIND_END, start: to_span(pos_reg),
                       stop: to_span(pos_reg), last: 1'b1};

        if (accept) begin
            if (in_eot) begin
                close_v    = (pend_reg != PEND_NONE);
                new_v      = 1'b1;
                pos_next_v = '0;
                start_next = '0;
                pend_next  = PEND_NONE;
                chars_next = '0;
                len_next   = '0;
            end else begin
                pos_next_v = pos_next(pos_reg);
                case (pend_reg)
                    PEND_NUMBER: begin
                        if (!is_digit(in_byte)) begin
                            close_v = 1'b1;
                            fresh   = 1'b1;
                        end
                    end
                    PEND_IDENT: begin
                        if (is_word_first(in_byte) || is_digit(in_byte)) begin
                            for (int i = 0; i < KEYWORD_MAX_LENGTH; i++) begin
                                if (len_reg == WLEN_BITS'(i)) begin
                                    chars_next[i] = in_byte;
                                end
                            end
                            // count stops one past the longest keyword
                            if (len_reg <= WLEN_BITS'(KEYWORD_MAX_LENGTH)) begin
                                len_next = len_reg + 1'b1;
                            end
                        end else begin
                            close_v = 1'b1;
                            fresh   = 1'b1;
                        end
                    end
                    PEND_OPFIRST: begin
                        if (in_byte == "=") begin
                            new_v     = 1'b1;
                            new_tok   = '{kind: pair_kind(chars_reg[0]),
                                          start: to_span(start_reg),
                                          stop: to_span(pos_next(pos_reg)), last: 1'b0};
                            pend_next = PEND_NONE;
                        end else begin
                            close_v = 1'b1;
                            fresh   = 1'b1;
                        end
                    end
                    default: begin
                        fresh = 1'b1;
                    end
                endcase

                if (fresh) begin
                    pend_next = PEND_NONE;
                    if (is_space(in_byte)) begin
                        pend_next = PEND_NONE;
                    end else if (is_digit(in_byte)) begin
                        pend_next  = PEND_NUMBER;
                        start_next = pos_reg;
                    end else if (is_word_first(in_byte)) begin
                        pend_next     = PEND_IDENT;
                        start_next    = pos_reg;
                        chars_next[0] = in_byte;
                        len_next      = WLEN_BITS'(1);
                    end else if (is_op_first(in_byte)) begin
                        pend_next     = PEND_OPFIRST;
                        start_next    = pos_reg;
                        chars_next[0] = in_byte;
                    end else begin
                        new_v   = 1'b1;
                        new_tok = '{kind: single_kind(in_byte), start: to_span(pos_reg),
                                    stop: to_span(pos_next(pos_reg)), last: 1'b0};
                    end
                end
            end
        end
    end

    always_comb begin
        push = accept && (close_v || new_v);
        if (close_v) begin
            push_rec = '{tok0: close_tok, tok1: new_tok, two: new_v};
        end else begin
            push_rec = '{tok0: new_tok, tok1: new_tok, two: 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            start_reg <= '0;
            pend_reg  <= PEND_NONE;
            chars_reg <= '0;
            len_reg   <= '0;
        end else begin
            pos_reg   <= pos_next_v;
            start_reg <= start_next;
            pend_reg  <= pend_next;
            chars_reg <= chars_next;
            len_reg   <= len_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tls_queue.sv =====
// Short record queue between the lexer front end and the token output stage.
`default_nettype none

module tls_queue
    import tls_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire record_t push_rec,
    output logic         full,
    input  wire logic    pop,
    output record_t      head,
    output logic         empty
);

    record_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]     count_reg, count_next;

    assign full  = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tls_back.sv =====
// Token output stage: splits queued records into single tokens behind an output register.
`default_nettype none

module tls_back
    import tls_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire record_t head,
    input  wire logic    empty,
    output logic         pop,
    output logic         out_valid,
    input  wire logic    out_ready,
    output token_t       out_tok
);

    logic   valid_reg, valid_next;
    logic   second_reg, second_next;
    token_t tok_reg;
    logic   load;

    assign load      = (!valid_reg || out_ready) && !empty;
    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

    always_comb begin
        valid_next  = valid_reg;
        second_next = second_reg;
        pop         = 1'b0;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            // a two-token record stays at the head until its second token is loaded
            if (!second_reg && head.two) begin
                second_next = 1'b1;
            end else begin
                second_next = 1'b0;
                pop         = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg <= second_reg ? head.tok1 : head.tok0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for token_lexer_stream_core: random source text checked against a token predictor.
`timescale 1ns / 100ps

module testbench;
    import tls_pkg::*;

    localparam int   RANDOM_ITEMS = 450;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   DRAIN_CYCLES = 20;
    localparam char_t TAB_CHAR    = 8'h09;
    localparam char_t LF_CHAR     = 8'h0A;

    // Tracks the lexer state and holds the tokens still owed by the block.
    class token_scoreboard;
        pos_t   position;
        pos_t   tok_begin;
        pend_t  pending;
        char_t  word_buf [KEYWORD_MAX_LENGTH];
        int     word_count;
        token_t expected_tokens [$];
        int     mismatches;
        int     tokens_seen;
        int     bytes_taken;
        int     texts_ended;

        function new();
            mismatches  = 0;
            tokens_seen = 0;
            bytes_taken = 0;
            texts_ended = 0;
            clear();
        endfunction

        function void clear();
            position   = '0;
            tok_begin  = '0;
            pending    = PEND_NONE;
            word_count = 0;
            foreach (word_buf[i]) word_buf[i] = '0;
        endfunction

        static function string keyword_text(int k);
            case (k)
                0:       return "func";
                1:       return "return";
                2:       return "var";
                3:       return "set";
                4:       return "if";
                5:       return "else";
                6:       return "while";
                default: return "";
            endcase
        endfunction

        // offsets stick at all-ones
        function pos_t advance(pos_t p);
            return (&p) ? p : p + 1'b1;
        endfunction

        function bit digit(char_t c);
            return (c >= "0") && (c <= "9");
        endfunction

        function bit word_char(char_t c);
            return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
        endfunction

        function bit blank(char_t c);
            return (c == " ") || (c == TAB_CHAR) || (c == LF_CHAR);
        endfunction

        function bit op_first(char_t c);
            return (c == "=") || (c == "!") || (c == "<") || (c == ">") || (c == ":");
        endfunction

        function kind_t lone_kind(char_t c);
            case (c)
                "=":     return KIND_ASSIGN;
                "+":     return KIND_PLUS;
                "-":     return KIND_MINUS;
                "*":     return KIND_STAR;
                "/":     return KIND_SLASH;
                "{":     return KIND_LBRACE;
                "}":     return KIND_RBRACE;
                "(":     return KIND_LPAREN;
                ")":     return KIND_RPAREN;
                "[":     return KIND_LBRACKET;
                "]":     return KIND_RBRACKET;
                "<":     return KIND_LT;
                ">":     return KIND_GT;
                ":":     return KIND_COLON;
                ";":     return KIND_SEMI;
                "&":     return KIND_AMP;
                default: return KIND_ERROR;
            endcase
        endfunction

        function kind_t paired_kind(char_t c);
            case (c)
                "=":     return KIND_EQ;
                "!":     return KIND_NE;
                "<":     return KIND_LE;
                ">":     return KIND_GE;
                default: return KIND_DEFINE;
            endcase
        endfunction

        // keyword test goes by character count, not by span
        function kind_t word_token_kind();
            string spelled;
            bit    same;
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
                spelled = keyword_text(k);
                if (word_count == spelled.len()) begin
                    same = 1'b1;
                    for (int i = 0; i < word_count; i++) begin
                        if (word_buf[i] != spelled[i]) same = 1'b0;
                    end
                    if (same) return KIND_KW_BASE + kind_t'(k);
                end
            end
            return KIND_IDENT;
        endfunction

        function void push_token(kind_t k, pos_t s, pos_t e, logic last);
            token_t t;
            t.kind  = k;
            t.start = s[SPAN_BITS-1:0];
            t.stop  = e[SPAN_BITS-1:0];
            t.last  = last;
            expected_tokens.push_back(t);
        endfunction

        function void add_char(char_t c);
            if (word_count < KEYWORD_MAX_LENGTH) word_buf[word_count] = c;
            if (word_count <= KEYWORD_MAX_LENGTH) word_count++;
        endfunction

        function void close_token(pos_t stop_at);
            case (pending)
                PEND_NUMBER:  push_token(KIND_NUMBER, tok_begin, stop_at, 1'b0);
                PEND_IDENT:   push_token(word_token_kind(), tok_begin, stop_at, 1'b0);
                PEND_OPFIRST: push_token(lone_kind(word_buf[0]), tok_begin, stop_at, 1'b0);
                default:      ;
            endcase
            pending = PEND_NONE;
        endfunction

        function void note_byte(char_t c, logic eot);
            pos_t p;
            p = position;
            bytes_taken++;
            if (eot) begin
                close_token(p);
                push_token(KIND_END, p, p, 1'b1);
                texts_ended++;
                clear();
                return;
            end
            position = advance(p);
            if (pending == PEND_NUMBER) begin
                if (digit(c)) return;
                close_token(p);
            end else if (pending == PEND_IDENT) begin
                if (word_char(c) || digit(c)) begin
                    add_char(c);
                    return;
                end
                close_token(p);
            end else if (pending == PEND_OPFIRST) begin
                if (c == "=") begin
                    push_token(paired_kind(word_buf[0]), tok_begin, advance(p), 1'b0);
                    pending = PEND_NONE;
                    return;
                end
                close_token(p);
            end
            if (blank(c)) return;
            if (digit(c)) begin
                pending   = PEND_NUMBER;
                tok_begin = p;
            end else if (word_char(c)) begin
                pending    = PEND_IDENT;
                tok_begin  = p;
                word_count = 0;
                add_char(c);
            end else if (op_first(c)) begin
                pending     = PEND_OPFIRST;
                tok_begin   = p;
                word_buf[0] = c;
            end else begin
                push_token(lone_kind(c), p, advance(p), 1'b0);
            end
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            $display("%0t: token %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_token(logic [OUT_DATA_BITS-1:0] data, logic last);
            token_t want;
            kind_t  k;
            span_t  s;
            span_t  e;
            k = data[KIND_BITS-1:0];
            s = data[KIND_BITS +: SPAN_BITS];
            e = data[KIND_BITS + SPAN_BITS +: SPAN_BITS];
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
                $display("%0t: token with none expected: kind %0d span %0d..%0d last %0b",
                         $time, k, s, e, last);
                mismatches++;
                return;
            end
            want = expected_tokens.pop_front();
            if (k !== want.kind)     report("kind", want.kind, k);
            if (s !== want.start)    report("start", want.start, s);
            if (e !== want.stop)     report("end", want.stop, e);
            if (last !== want.last)  report("last", want.last, last);
        endfunction
    endclass

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;   // [7:0] text_byte
    logic                     s_tlast  = 1'b0; // end_of_text
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;         // [4:0] kind, [28:5] start, [52:29] end
    logic                     m_tlast;         // last_result

    token_scoreboard lexer_sb;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              items_sent     = 0;
    int              cycle_count    = 0;

    token_lexer_stream_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) lexer_sb.check_token(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic set_phase(int ph);
        case (ph)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
        endcase
    endtask

    // valid stays up from one transaction to the next unless a gap is taken
    task automatic send_item(char_t c, logic eot);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        lexer_sb.note_byte(c, eot);
        items_sent++;
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++) send_item(txt[i], 1'b0);
    endtask

    function automatic char_t random_word_char(bit first);
        int r;
        r = first ? $urandom_range(52) : $urandom_range(62);
        if (r < 26) return char_t'("a" + r);
        if (r < 52) return char_t'("A" + (r - 26));
        if (r == 52) return "_";
        return char_t'("0" + (r - 53));
    endfunction

    task automatic send_random_token();
        string singles;
        string pairs;
        string spelled;
        int    pick;
        int    len;
        singles = "=+-*/{}()[]<>:;&";
        pairs   = "=!<>:";
        pick    = $urandom_range(99);
        if (pick < 14) begin
            send_text(token_scoreboard::keyword_text($urandom_range(KEYWORD_COUNT - 1)));
        end else if (pick < 24) begin
            // near misses: cut short, extended by one or two word characters, or one letter off
            spelled = token_scoreboard::keyword_text($urandom_range(KEYWORD_COUNT - 1));
            case ($urandom_range(2))
                0: send_text(spelled.substr(0, spelled.len() - 2));
                1: begin
                    send_text(spelled);
                    repeat ($urandom_range(2, 1)) send_item(random_word_char(1'b0), 1'b0);
                end
                default: begin
                    spelled[$urandom_range(spelled.len() - 1)] = random_word_char(1'b1);
                    send_text(spelled);
                end
            endcase
        end else if (pick < 38) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(12, 7) : $urandom_range(5, 1);
            send_item(random_word_char(1'b1), 1'b0);
            repeat (len - 1) send_item(random_word_char(1'b0), 1'b0);
        end else if (pick < 50) begin
            repeat ($urandom_range(6, 1)) send_item(char_t'("0" + $urandom_range(9)), 1'b0);
        end else if (pick < 62) begin
            send_item(pairs[$urandom_range(pairs.len() - 1)], 1'b0);
            send_item("=", 1'b0);
        end else if (pick < 78) begin
            send_item(singles[$urandom_range(singles.len() - 1)], 1'b0);
        end else if (pick < 82) begin
            send_item("!", 1'b0);
        end else if (pick < 90) begin
            send_item(char_t'($urandom_range(255)), 1'b0);
        end else begin
            case ($urandom_range(2))
                0:       send_item(" ", 1'b0);
                1:       send_item(TAB_CHAR, 1'b0);
                default: send_item(LF_CHAR, 1'b0);
            endcase
        end
    endtask

    initial begin
        int random_start;
        lexer_sb = new();
        set_phase(0);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // zero byte, top byte, control byte and a lone bang are all errors
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h01, 1'b0);
        send_text("!a==<>=:=!");
        send_text("09_Az");
        send_item(TAB_CHAR, 1'b0);
        send_item(LF_CHAR, 1'b0);
        send_item("x", 1'b0);
        send_item(8'hFF, 1'b1);    // flush closes the pending identifier
        send_item(8'h00, 1'b1);    // empty text
        send_item("<", 1'b0);
        send_item(8'hA5, 1'b1);    // flush closes a pending operator

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            set_phase((items_sent - random_start) * 4 / RANDOM_ITEMS);
            send_random_token();
            if ($urandom_range(1)) send_item(" ", 1'b0);
            if ($urandom_range(29) == 0) send_item(char_t'($urandom_range(255)), 1'b1);
        end
        send_item(char_t'($urandom_range(255)), 1'b1);
        s_tvalid <= 1'b0;

        while (lexer_sb.expected_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes and flushes across %0d texts, checked %0d tokens",
                 lexer_sb.bytes_taken, lexer_sb.texts_ended, lexer_sb.tokens_seen);
        $display("Idle and stall phases: none, sender, receiver, both; mismatches: %0d",
                 lexer_sb.mismatches);
        if (lexer_sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
